// File: sv/bpdc_pkg.sv
// Package for the button press duration classifier.
// Holds the stage and event codes, register indexes and the threshold bundle.
// Standalone: no dependencies.
`timescale 1ns / 1ps

package bpdc_pkg;

  typedef enum logic [2:0] {
    STAGE_IDLE      = 3'd0,
    STAGE_PRESSED   = 3'd1,
    STAGE_HOLD      = 3'd2,
    STAGE_LONG      = 3'd3,
    STAGE_VERY_LONG = 3'd4
  } stage_t;

  typedef enum logic [3:0] {
    EV_NONE              = 4'd0,
    EV_DOWN              = 4'd1,
    EV_CLICK_RELEASE     = 4'd2,
    EV_HOLD_BEGIN        = 4'd3,
    EV_HOLD_RELEASE      = 4'd4,
    EV_LONG_BEGIN        = 4'd5,
    EV_LONG_RELEASE      = 4'd6,
    EV_VERY_LONG_BEGIN   = 4'd7,
    EV_VERY_LONG_RELEASE = 4'd8
  } event_t;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned ThrW   = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] REG_HOLD      = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LONG      = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_VERY_LONG = 2'd2;

  localparam logic [ThrW-1:0] HOLD_RESET      = 32'd500000;
  localparam logic [ThrW-1:0] LONG_RESET      = 32'd2000000;
  localparam logic [ThrW-1:0] VERY_LONG_RESET = 32'd5000000;

  typedef struct packed {
    logic [ThrW-1:0] hold;
    logic [ThrW-1:0] long_hold;
    logic [ThrW-1:0] very_long;
  } thresholds_t;

endpackage

// File: sv/bpdc_fsm.sv
// Press stage machine: holds stage and press start time, classifies one poll.
// Depends on bpdc_pkg.
`timescale 1ns / 1ps

module bpdc_fsm import bpdc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             step,
  input  logic             button_down,
  input  logic [TimeW-1:0] now_us,
  input  thresholds_t      thr,
  output event_t           event_code
);

  stage_t           stage, stage_next;
  logic [TimeW-1:0] start_time;
  logic [TimeW-1:0] elapsed;
  logic             over_hold, over_long, over_very_long;

  // Elapsed time wraps mod 2^64; thresholds are 32 bits.
  assign elapsed        = now_us - start_time;
  assign over_hold      = (elapsed[TimeW-1:ThrW] != '0) || (elapsed[ThrW-1:0] > thr.hold);
  assign over_long      = (elapsed[TimeW-1:ThrW] != '0) || (elapsed[ThrW-1:0] > thr.long_hold);
  assign over_very_long = (elapsed[TimeW-1:ThrW] != '0) || (elapsed[ThrW-1:0] > thr.very_long);

  always_ff @(posedge clk) begin
    if (rst) begin
      stage      <= STAGE_IDLE;
      start_time <= '0;
    end else if (step) begin
      stage <= stage_next;
      if ((stage != STAGE_PRESSED) && (stage != STAGE_HOLD) && (stage != STAGE_LONG) &&
          (stage != STAGE_VERY_LONG) && button_down) begin
        start_time <= now_us;
      end
    end
  end

  always_comb begin
    stage_next = stage;
    event_code = EV_NONE;
    case (stage)
      STAGE_PRESSED: begin
        if (!button_down) begin
          stage_next = STAGE_IDLE;
          event_code = EV_CLICK_RELEASE;
        end else if (over_hold) begin
          stage_next = STAGE_HOLD;
          event_code = EV_HOLD_BEGIN;
        end
      end
      STAGE_HOLD: begin
        if (!button_down) begin
          stage_next = STAGE_IDLE;
          event_code = EV_HOLD_RELEASE;
        end else if (over_long) begin
          stage_next = STAGE_LONG;
          event_code = EV_LONG_BEGIN;
        end
      end
      STAGE_LONG: begin
        if (!button_down) begin
          stage_next = STAGE_IDLE;
          event_code = EV_LONG_RELEASE;
        end else if (over_very_long) begin
          stage_next = STAGE_VERY_LONG;
          event_code = EV_VERY_LONG_BEGIN;
        end
      end
      STAGE_VERY_LONG: begin
        if (!button_down) begin
          stage_next = STAGE_IDLE;
          event_code = EV_VERY_LONG_RELEASE;
        end
      end
      default: begin
        // Idle and any stray code: a press starts timing.
        if (button_down) begin
          stage_next = STAGE_PRESSED;
          event_code = EV_DOWN;
        end else begin
          stage_next = STAGE_IDLE;
        end
      end
    endcase
  end

endmodule

// File: sv/button_press_duration_classifier.sv
// Top level of the button press duration classifier: input register,
// threshold registers, stage machine and result register. Depends on bpdc_pkg, bpdc_fsm.
`timescale 1ns / 1ps
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  -------------------------------------
//  s_*       in         s_tvalid / s_tready       s_tdata[0] button_down, [64:1] now_us
//  m_*       out        m_tvalid / m_tready       m_tdata[3:0] event_code
//  cfg_*     in         cfg_we (no wait)          cfg_index, cfg_wdata (32 bits)
//
//  One poll per cycle sustained while m_tready holds high. A poll's event
//  reaches m_tdata through the input register, which loads at its input
//  transaction, and then the result register, which loads on a step.
//  Reset (rst, synchronous) empties both registers, returns the stage to idle
//  and loads the default thresholds.
//  A stall on m_tready holds the result; an empty input register still takes one
//  more transaction, then s_tready drops until the result is taken.

module button_press_duration_classifier import bpdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [71:0]        s_tdata,   // [0] button_down, [64:1] now_us, [71:65] zero
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [3:0] event_code, [7:4] zero
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ThrW-1:0]    cfg_wdata
);

  thresholds_t      thr;
  logic             in_valid;
  logic             in_button;
  logic [TimeW-1:0] in_now;
  logic             step;
  event_t           fsm_event;
  event_t           out_event;

  // Threshold registers; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      thr.hold      <= HOLD_RESET;
      thr.long_hold <= LONG_RESET;
      thr.very_long <= VERY_LONG_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HOLD:      thr.hold      <= cfg_wdata;
        REG_LONG:      thr.long_hold <= cfg_wdata;
        REG_VERY_LONG: thr.very_long <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance the held poll through the machine whenever the result slot frees.
  assign step     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_button <= s_tdata[0];
      in_now    <= s_tdata[64:1];
    end
  end

  bpdc_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .button_down (in_button),
    .now_us      (in_now),
    .thr         (thr),
    .event_code  (fsm_event)
  );

  // Result register: load on a step, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_event <= fsm_event;
    end
  end

  assign m_tdata = {4'b0000, out_event};

endmodule

// File: sv/bpdc_checker.sv
// Port-level checker for the button press duration classifier, bound to the top.
// Depends on bpdc_pkg and button_press_duration_classifier.
`timescale 1ns / 1ps

module bpdc_checker import bpdc_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // An empty result slot never blocks the input side.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with no result pending");

  // Only defined event codes leave the block.
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:4] == 4'd0) && (m_tdata[3:0] <= 4'd8))
    else $error("undefined event code");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind button_press_duration_classifier bpdc_checker u_bpdc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// File: tb/button_press_duration_classifier_tb.sv
// Self-checking testbench for the button press duration classifier.
// Predicts the event code of every poll and checks each result in order.
// Depends on bpdc_pkg and the button_press_duration_classifier RTL.
`timescale 1ns / 1ps

module button_press_duration_classifier_tb;
  import bpdc_pkg::*;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RESET_CYCLES = 12;
  // Slowest correct run is roughly 950 polls with input gaps, output stalls and
  // pipeline passes, plus the long output stall and idle time around threshold writes.
  localparam int unsigned CYCLE_LIMIT  = 250000;
  // Pipeline depth plus margin; let the block go quiet before a write.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned STALL_CYCLES  = 300;
  localparam int unsigned RANDOM_PHASES = 8;
  localparam int unsigned PHASE_POLLS   = 112;
  localparam int unsigned MAX_REPORTS   = 10;

  // Index 3 of the write port decodes to no register.
  localparam logic [CfgIdxW-1:0] REG_NONE = 2'd3;
  localparam logic [TimeW-1:0]   TIME_MAX = '1;

  // Drive every input to a known value from time zero.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               s_tvalid  = 1'b0;
  logic               s_tready;
  logic [71:0]        s_tdata   = '0;   // [0] button_down, [64:1] now_us, [71:65] zero
  logic               m_tvalid;
  logic               m_tready  = 1'b0;
  logic [7:0]         m_tdata;          // [3:0] event_code, [7:4] zero
  logic               cfg_we    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ThrW-1:0]    cfg_wdata = '0;

  // Predictor state: stage machine, press timestamp and thresholds.
  stage_t          press_stage;
  logic [TimeW-1:0] press_start;
  logic [ThrW-1:0]  hold_thr;
  logic [ThrW-1:0]  long_thr;
  logic [ThrW-1:0]  very_long_thr;

  // Events predicted for accepted polls, oldest first.
  event_t pending_events[$];

  int unsigned cycle_count    = 0;
  int unsigned poll_count     = 0;
  int unsigned events_checked = 0;
  int unsigned mismatches     = 0;
  int unsigned settings_count = 0;
  int unsigned event_seen[16];

  // Idle controls shared between the test tasks and the two drivers.
  bit          tx_gaps        = 1'b0;
  bit          rx_gaps        = 1'b0;
  int unsigned stall_request  = 0;

  button_press_duration_classifier dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #CLK_HALF clk = ~clk;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Advance the predicted stage machine by one poll and return its event.
  // At most one stage step per poll; a press in idle only enters the pressed stage.
  function automatic event_t classify_poll(input bit down, input logic [TimeW-1:0] now);
    logic [TimeW-1:0] elapsed;
    event_t           ev;
    elapsed = now - press_start;   // modular, so a backwards clock looks very long
    ev      = EV_NONE;
    case (press_stage)
      STAGE_PRESSED: begin
        if (!down) begin
          press_stage = STAGE_IDLE;
          ev          = EV_CLICK_RELEASE;
        end else if (elapsed > {32'd0, hold_thr}) begin
          press_stage = STAGE_HOLD;
          ev          = EV_HOLD_BEGIN;
        end
      end
      STAGE_HOLD: begin
        if (!down) begin
          press_stage = STAGE_IDLE;
          ev          = EV_HOLD_RELEASE;
        end else if (elapsed > {32'd0, long_thr}) begin
          press_stage = STAGE_LONG;
          ev          = EV_LONG_BEGIN;
        end
      end
      STAGE_LONG: begin
        if (!down) begin
          press_stage = STAGE_IDLE;
          ev          = EV_LONG_RELEASE;
        end else if (elapsed > {32'd0, very_long_thr}) begin
          press_stage = STAGE_VERY_LONG;
          ev          = EV_VERY_LONG_BEGIN;
        end
      end
      STAGE_VERY_LONG: begin
        if (!down) begin
          press_stage = STAGE_IDLE;
          ev          = EV_VERY_LONG_RELEASE;
        end
      end
      default: begin
        if (down) begin
          press_start = now;
          press_stage = STAGE_PRESSED;
          ev          = EV_DOWN;
        end else begin
          press_stage = STAGE_IDLE;
        end
      end
    endcase
    return ev;
  endfunction

  // Threshold that the next advance from the predicted stage is compared with.
  function automatic logic [TimeW-1:0] next_threshold();
    case (press_stage)
      STAGE_PRESSED: return {32'd0, hold_thr};
      STAGE_HOLD:    return {32'd0, long_thr};
      default:       return {32'd0, very_long_thr};
    endcase
  endfunction

  function automatic logic [TimeW-1:0] random_time();
    return {$urandom, $urandom};
  endfunction

  // Mix of extremes, small values that sequences reach quickly, and full range.
  function automatic logic [ThrW-1:0] random_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return ThrW'($urandom_range(0, 2000));
      4:       return ThrW'($urandom_range(0, 2000000));
      default: return $urandom;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------

  // Offer one poll, hold it until the transaction completes, then predict.
  task automatic send_poll(input bit down, input logic [TimeW-1:0] now);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, now, down};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_events.push_back(classify_poll(down, now));
    poll_count++;
  endtask

  // Drop valid, wait for every predicted event, then let the pipeline settle.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write one threshold register while the block is idle.
  task automatic write_threshold(input logic [CfgIdxW-1:0] idx, input logic [ThrW-1:0] value);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      REG_HOLD:      hold_thr      = value;
      REG_LONG:      long_thr      = value;
      REG_VERY_LONG: very_long_thr = value;
      default:       ;   // no register behind this index
    endcase
  endtask

  task automatic write_all_thresholds(input logic [ThrW-1:0] hold_v,
                                      input logic [ThrW-1:0] long_v,
                                      input logic [ThrW-1:0] very_v);
    write_threshold(REG_HOLD, hold_v);
    write_threshold(REG_LONG, long_v);
    write_threshold(REG_VERY_LONG, very_v);
    settings_count++;
  endtask

  // Receiver: draw a stall before each result; honor a long hold-off request.
  initial begin : result_sink
    int unsigned stall;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (stall_request > 0) begin
        stall         = stall_request;
        stall_request = 0;
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      stall = rx_gaps ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  // ---------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------

  // Compare every result transaction with the oldest prediction.
  always @(posedge clk) begin : event_checker
    event_t want;
    if (!rst && m_tvalid && m_tready) begin
      events_checked++;
      event_seen[m_tdata[3:0]]++;
      if (pending_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected event %0d with nothing predicted", $realtime, m_tdata[3:0]);
      end else begin
        want = pending_events.pop_front();
        if (m_tdata[3:0] !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: event_code expected %0d (%s) got %0d",
                     $realtime, want, want.name(), m_tdata[3:0]);
        end
      end
    end
  end

  // Stop a hung run.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("button_press_duration_classifier regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Walk the full ladder with the reset thresholds; equal elapsed never advances.
  task automatic test_reset_thresholds();
    send_poll(1'b1, 64'd0);
    send_poll(1'b1, 64'd500000);
    send_poll(1'b1, 64'd500001);
    send_poll(1'b1, 64'd2000001);
    send_poll(1'b1, 64'd5000001);
    send_poll(1'b0, 64'd6000000);
  endtask

  // Short press at the top of the clock range, and a release seen in idle.
  task automatic test_click_release();
    send_poll(1'b0, TIME_MAX);
    send_poll(1'b1, TIME_MAX);
    send_poll(1'b0, TIME_MAX);
  endtask

  // Zero thresholds advance on the first tick; all-ones need 2^32 elapsed.
  task automatic test_threshold_extremes();
    write_all_thresholds('0, '0, '0);
    send_poll(1'b1, 64'd100);
    send_poll(1'b1, 64'd100);
    send_poll(1'b1, 64'd101);
    send_poll(1'b1, 64'd101);
    send_poll(1'b1, 64'd102);
    send_poll(1'b0, 64'd102);
    write_all_thresholds('1, '1, '1);
    send_poll(1'b1, 64'd0);
    send_poll(1'b1, 64'hFFFF_FFFF);
    send_poll(1'b1, 64'h1_0000_0000);
    send_poll(1'b0, 64'h1_0000_0000);
  endtask

  // One step per poll past several thresholds, clock wrap, backwards clock,
  // and a write to the unused index that must leave the thresholds alone.
  task automatic test_step_wrap_and_unused_index();
    write_all_thresholds(32'd10, 32'd20, 32'd30);
    send_poll(1'b1, TIME_MAX - 64'd4);
    send_poll(1'b1, 64'd3);
    send_poll(1'b1, 64'd1000);
    send_poll(1'b1, 64'd1000);
    send_poll(1'b0, 64'd1000);
    write_threshold(REG_NONE, 32'd0);
    send_poll(1'b1, 64'd1000);
    send_poll(1'b1, 64'd999);
    send_poll(1'b0, 64'd999);
  endtask

  // Mostly well-formed presses: timestamps land just around the next
  // threshold so every stage is reached; some jump anywhere, even backwards.
  task automatic press_sequence();
    logic [TimeW-1:0] start_t;
    logic [TimeW-1:0] t;
    int unsigned      steps;
    start_t = ($urandom_range(0, 7) == 0) ? TIME_MAX - 64'($urandom_range(0, 3000))
                                          : random_time();
    send_poll(1'b1, start_t);
    t     = start_t;
    steps = $urandom_range(1, 8);
    repeat (steps) begin
      case ($urandom_range(0, 5))
        0, 1, 2: t = start_t + next_threshold() + 64'($urandom_range(0, 2)) - 64'd1;
        3:       t = t + 64'($urandom_range(0, 50));
        4:       t = random_time();
        default: ;   // same timestamp again
      endcase
      send_poll(1'b1, t);
    end
    send_poll(1'b0, t + 64'($urandom_range(0, 100)));
    if ($urandom_range(0, 5) == 0)
      send_poll(1'b0, t + 64'($urandom_range(0, 100)));
  endtask

  // Random phases, each with fresh thresholds and its own idle pattern.
  task automatic test_random_phases();
    int unsigned phase_end;
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      write_all_thresholds(random_threshold(), random_threshold(), random_threshold());
      if ($urandom_range(0, 3) == 0)
        write_threshold(REG_NONE, $urandom);
      // Keep the first phase back-to-back on both sides.
      tx_gaps   = (phase != 0) && ($urandom_range(0, 3) != 0);
      rx_gaps   = (phase != 0) && ($urandom_range(0, 3) != 0);
      phase_end = poll_count + PHASE_POLLS;
      while (poll_count < phase_end) begin
        if ($urandom_range(0, 4) != 0)
          press_sequence();
        else
          repeat ($urandom_range(1, 3)) send_poll(1'($urandom_range(0, 1)), random_time());
      end
    end
  endtask

  // Hold the output off for a long stretch while polls keep coming, so the
  // pipeline fills and s_tready drops; then release and check the backlog.
  task automatic test_output_stall();
    write_all_thresholds(32'd5, 32'd15, 32'd40);
    tx_gaps       = 1'b0;
    rx_gaps       = 1'b0;
    stall_request = STALL_CYCLES;
    for (int unsigned i = 0; i < 40; i++)
      send_poll(($urandom_range(0, 7) != 0), 64'(i * 7));
    drain();
  endtask

  initial begin : main
    press_stage   = STAGE_IDLE;
    press_start   = '0;
    hold_thr      = HOLD_RESET;
    long_thr      = LONG_RESET;
    very_long_thr = VERY_LONG_RESET;

    // Hold reset once, release it on a rising edge.
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_thresholds();
    test_click_release();
    test_threshold_extremes();
    test_step_wrap_and_unused_index();
    test_output_stall();
    test_random_phases();

    drain();
    if (pending_events.size() != 0) begin
      mismatches++;
      $display("%0d predicted events never arrived", pending_events.size());
    end

    $display("Covered %0d polls and %0d events over %0d threshold settings in %0d cycles",
             poll_count, events_checked, settings_count, cycle_count);
    $display("Events: down %0d click %0d hold %0d/%0d long %0d/%0d very long %0d/%0d",
             event_seen[EV_DOWN], event_seen[EV_CLICK_RELEASE],
             event_seen[EV_HOLD_BEGIN], event_seen[EV_HOLD_RELEASE],
             event_seen[EV_LONG_BEGIN], event_seen[EV_LONG_RELEASE],
             event_seen[EV_VERY_LONG_BEGIN], event_seen[EV_VERY_LONG_RELEASE]);
    if (mismatches == 0) begin
      $display("button_press_duration_classifier regression: pass");
    end else begin
      $display("button_press_duration_classifier regression: fail");
    end
    $finish;
  end

endmodule
